### rtl/core/pwc_mac_pkg.sv
// ----------------------------------------------------------------------------
// pwc_mac_pkg
// Shared constants, register indexes and types of the 4x4 pointwise MAC unit.
// ----------------------------------------------------------------------------
package pwc_mac_pkg;

	// Block geometry and fixed-point format
	localparam int NUM_CH        = 4;
	localparam int WEIGHT_BITS   = 16;   // Q2.14
	localparam int PRODUCT_SHIFT = 6;    // Q10.22 -> Q16.16
	localparam int ACT_BITS_DEF  = 16;   // Q8.8
	localparam int ACC_BITS_DEF  = 32;   // Q16.16

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = NUM_CH * WEIGHT_BITS;
	localparam int CNT_BITS      = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_ROW0     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_ROW1     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_ROW2     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_ROW3     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_IN_CHS   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_OUT_CHS  = 3'd5;

	localparam logic [CNT_BITS-1:0] ACTIVE_CHS_RESET = 3'd4;

	// Per-cell enables: does this cell's input channel count, and which
	// output channels get updated.
	typedef struct packed {
		logic              in_on;
		logic [NUM_CH-1:0] out_on;
	} cell_ctl_t;

	// Width of the exact running sum: accumulator or shifted product,
	// plus headroom for the additions along the chain.
	function automatic int sum_width(input int act_bits, input int acc_bits);
		int sh_w;
		sh_w = act_bits + WEIGHT_BITS - PRODUCT_SHIFT;
		return ((acc_bits > sh_w) ? acc_bits : sh_w) + 3;
	endfunction

endpackage

### rtl/core/pwc_mac_cell.sv
// ----------------------------------------------------------------------------
// pwc_mac_cell
// One chain cell: adds one input channel's products to the four partial sums.
// ----------------------------------------------------------------------------
module pwc_mac_cell import pwc_mac_pkg::*; #(
	parameter int ACT_BITS = ACT_BITS_DEF,
	parameter int ACC_BITS = ACC_BITS_DEF,
	parameter int CELL_IDX = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   up_valid,
	output logic                                   up_ready,
	input  logic signed [ACT_BITS-1:0]             up_act [NUM_CH],
	input  logic signed [sum_width(ACT_BITS, ACC_BITS)-1:0] up_acc [NUM_CH],
	input  logic signed [WEIGHT_BITS-1:0]          wcol   [NUM_CH],
	input  cell_ctl_t                              ctl,
	output logic                                   dn_valid,
	input  logic                                   dn_ready,
	output logic signed [ACT_BITS-1:0]             dn_act [NUM_CH],
	output logic signed [sum_width(ACT_BITS, ACC_BITS)-1:0] dn_acc [NUM_CH]
);

	localparam int SUM_W = sum_width(ACT_BITS, ACC_BITS);
	localparam int PROD_W = ACT_BITS + WEIGHT_BITS;
	localparam int SH_W = PROD_W - PRODUCT_SHIFT;

	logic                      valid_q;
	logic signed [ACT_BITS-1:0] act_q [NUM_CH];
	logic signed [SUM_W-1:0]    acc_q [NUM_CH];
	logic signed [PROD_W-1:0]   prod  [NUM_CH];
	logic signed [SH_W-1:0]     prod_sh [NUM_CH];
	logic signed [SUM_W-1:0]    acc_nxt [NUM_CH];

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		for (int j = 0; j < NUM_CH; j++) begin
			prod[j]    = up_act[CELL_IDX] * wcol[j];
			// floor shift: drop the low bits of the two's complement product
			prod_sh[j] = prod[j][PROD_W-1:PRODUCT_SHIFT];
			if (ctl.in_on && ctl.out_on[j]) begin
				acc_nxt[j] = up_acc[j] + SUM_W'(prod_sh[j]);
			end else begin
				acc_nxt[j] = up_acc[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			act_q <= up_act;
			acc_q <= acc_nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_act   = act_q;
	assign dn_acc   = acc_q;

endmodule

### rtl/core/pwc_mac_sat.sv
// ----------------------------------------------------------------------------
// pwc_mac_sat
// Output stage: saturates the four sums to the accumulator width and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module pwc_mac_sat import pwc_mac_pkg::*; #(
	parameter int ACT_BITS = ACT_BITS_DEF,
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   up_valid,
	output logic                                   up_ready,
	input  logic signed [sum_width(ACT_BITS, ACC_BITS)-1:0] up_acc [NUM_CH],
	output logic                                   dn_valid,
	input  logic                                   dn_ready,
	output logic signed [ACC_BITS-1:0]             dn_acc [NUM_CH]
);

	localparam int SUM_W = sum_width(ACT_BITS, ACC_BITS);

	logic                      valid_q;
	logic signed [ACC_BITS-1:0] acc_q   [NUM_CH];
	logic signed [ACC_BITS-1:0] acc_sat [NUM_CH];
	logic [SUM_W-ACC_BITS:0]    top_bits [NUM_CH];

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		for (int j = 0; j < NUM_CH; j++) begin
			top_bits[j] = up_acc[j][SUM_W-1:ACC_BITS-1];
			if ((&top_bits[j]) || !(|top_bits[j])) begin
				acc_sat[j] = up_acc[j][ACC_BITS-1:0];
			end else if (up_acc[j][SUM_W-1]) begin
				acc_sat[j] = {1'b1, {(ACC_BITS-1){1'b0}}};
			end else begin
				acc_sat[j] = {1'b0, {(ACC_BITS-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			acc_q <= acc_sat;
		end
	end

	assign dn_valid = valid_q;
	assign dn_acc   = acc_q;

endmodule

### rtl/core/pointwise_conv_4x4_mac_unit.sv
// ----------------------------------------------------------------------------
// pointwise_conv_4x4_mac_unit
// 1x1 convolution register block: acc_out = sat(acc_in + W x act), 4x4.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one pixel per transfer, four Q8.8
//    activations and the four running Q16.16 accumulators of that pixel.
//  - Output channel (out_valid/out_ready): one transfer per pixel with the
//    four updated accumulators, in input order.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready.
//    Index 0..3 write weight rows (input channel 0 in the low 16 bits),
//    4 and 5 set active input/output channel counts (low 3 bits). Other
//    indexes are dropped. Write only while no pixel is in flight.
//  - Datapath is a chain of four cells, one per input channel; each adds
//    its channel's products to the partial sums and hands them on. A final
//    stage saturates and holds the result.
//  - Pipeline: five register stages, the four cells and then the output
//    stage; out_valid rises once a pixel has passed through all of them.
//  - Throughput: one pixel per cycle; every stage has its own valid and
//    stalls only when the stage after it is full and not draining.
//  - When out_ready is low the chain keeps filling until all five stages
//    are occupied, then in_ready drops.
//  - Reset: pipeline empties, weights clear to zero, both counts go to 4.
// ----------------------------------------------------------------------------
module pointwise_conv_4x4_mac_unit import pwc_mac_pkg::*; #(
	parameter int ACT_BITS = ACT_BITS_DEF,
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [ACT_BITS-1:0] act_ch0,
	input  logic signed [ACT_BITS-1:0] act_ch1,
	input  logic signed [ACT_BITS-1:0] act_ch2,
	input  logic signed [ACT_BITS-1:0] act_ch3,
	input  logic signed [ACC_BITS-1:0] acc_in0,
	input  logic signed [ACC_BITS-1:0] acc_in1,
	input  logic signed [ACC_BITS-1:0] acc_in2,
	input  logic signed [ACC_BITS-1:0] acc_in3,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ACC_BITS-1:0] acc_out0,
	output logic signed [ACC_BITS-1:0] acc_out1,
	output logic signed [ACC_BITS-1:0] acc_out2,
	output logic signed [ACC_BITS-1:0] acc_out3
);

	localparam int SUM_W = sum_width(ACT_BITS, ACC_BITS);

	// Configuration registers
	logic [CFG_DATA_BITS-1:0] weight_q [NUM_CH];
	logic [CNT_BITS-1:0]      act_in_chs_q;
	logic [CNT_BITS-1:0]      act_out_chs_q;

	// Chain links: index k feeds cell k, index NUM_CH feeds the output stage
	logic                      link_valid [NUM_CH+1];
	logic                      link_ready [NUM_CH+1];
	logic signed [ACT_BITS-1:0] link_act  [NUM_CH+1][NUM_CH];
	logic signed [SUM_W-1:0]    link_acc  [NUM_CH+1][NUM_CH];
	logic signed [ACC_BITS-1:0] out_acc   [NUM_CH];
	logic [NUM_CH-1:0]          stage_v;

	// ------------------------------------------------------------------
	// Config write port: registered writes, never back-pressures
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_CH; j++) begin
				weight_q[j] <= '0;
			end
			act_in_chs_q  <= ACTIVE_CHS_RESET;
			act_out_chs_q <= ACTIVE_CHS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WEIGHT_ROW0:    weight_q[0]   <= cfg_data;
				REG_WEIGHT_ROW1:    weight_q[1]   <= cfg_data;
				REG_WEIGHT_ROW2:    weight_q[2]   <= cfg_data;
				REG_WEIGHT_ROW3:    weight_q[3]   <= cfg_data;
				REG_ACTIVE_IN_CHS:  act_in_chs_q  <= cfg_data[CNT_BITS-1:0];
				REG_ACTIVE_OUT_CHS: act_out_chs_q <= cfg_data[CNT_BITS-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Chain entry: gather the pixel, widen accumulators to the sum width
	// ------------------------------------------------------------------
	assign link_valid[0] = in_valid;
	assign in_ready      = link_ready[0];

	assign link_act[0][0] = act_ch0;
	assign link_act[0][1] = act_ch1;
	assign link_act[0][2] = act_ch2;
	assign link_act[0][3] = act_ch3;
	assign link_acc[0][0] = SUM_W'(acc_in0);
	assign link_acc[0][1] = SUM_W'(acc_in1);
	assign link_acc[0][2] = SUM_W'(acc_in2);
	assign link_acc[0][3] = SUM_W'(acc_in3);

	// ------------------------------------------------------------------
	// Cell row: cell k owns input channel k (weight column k)
	// ------------------------------------------------------------------
	for (genvar k = 0; k < NUM_CH; k++) begin : g_cell
		logic signed [WEIGHT_BITS-1:0] wcol [NUM_CH];
		cell_ctl_t                     ctl;

		always_comb begin
			for (int j = 0; j < NUM_CH; j++) begin
				wcol[j]       = weight_q[j][k*WEIGHT_BITS +: WEIGHT_BITS];
				ctl.out_on[j] = (act_out_chs_q > CNT_BITS'(j));
			end
			// counts of 5..7 enable every channel, same as 4
			ctl.in_on = (act_in_chs_q > CNT_BITS'(k));
		end

		pwc_mac_cell #(
			.ACT_BITS (ACT_BITS),
			.ACC_BITS (ACC_BITS),
			.CELL_IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[k]),
			.up_ready (link_ready[k]),
			.up_act   (link_act[k]),
			.up_acc   (link_acc[k]),
			.wcol     (wcol),
			.ctl      (ctl),
			.dn_valid (link_valid[k+1]),
			.dn_ready (link_ready[k+1]),
			.dn_act   (link_act[k+1]),
			.dn_acc   (link_acc[k+1])
		);

		assign stage_v[k] = link_valid[k+1];
	end

	// ------------------------------------------------------------------
	// Output stage: saturate and hold for the receiver
	// ------------------------------------------------------------------
	pwc_mac_sat #(
		.ACT_BITS (ACT_BITS),
		.ACC_BITS (ACC_BITS)
	) u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (link_valid[NUM_CH]),
		.up_ready (link_ready[NUM_CH]),
		.up_acc   (link_acc[NUM_CH]),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_acc   (out_acc)
	);

	assign acc_out0 = out_acc[0];
	assign acc_out1 = out_acc[1];
	assign acc_out2 = out_acc[2];
	assign acc_out3 = out_acc[3];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// an empty first cell always takes a pixel
	a_entry_free: assert property (@(posedge clk) disable iff (!arst_n)
		!stage_v[0] |-> in_ready)
		else $error("in_ready low with first cell empty");

	// an accepted pixel lands in the first cell
	a_entry_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stage_v[0])
		else $error("accepted pixel lost at chain entry");

	// a full chain behind a stalled output must push back
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && (&stage_v) |-> !in_ready)
		else $error("input accepted while whole chain is stalled");

	// a result only appears after the last cell held a pixel
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stage_v[NUM_CH-1]))
		else $error("result appeared with no pixel in last cell");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 pointwise MAC unit. A short table of
// directed pixels and register writes runs first, then random phases. Each
// phase reprograms the weights and channel counts while the unit is empty
// and streams random pixels, mostly with random gaps and output stalls.
// Outputs are checked against typed-in results or a local fixed-point model.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pwc_mac_pkg::*;

	localparam int ACT_W          = ACT_BITS_DEF;
	localparam int ACC_W          = ACC_BITS_DEF;
	localparam int HALF_PERIOD    = 4;
	localparam int PIPE_LATENCY   = 5;
	localparam int TAIL_CYCLES    = 4 * PIPE_LATENCY;
	localparam int WATCHDOG_LIMIT = 400;   // idle cycles with no transfer at all
	localparam int MAX_GAP        = 10;
	localparam int NUM_PHASES     = 12;
	localparam int PHASE_PIXELS   = 62;
	localparam int PAUSE_PHASE    = 2;

	localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	// Register indexes that the unit has to drop
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE7 = 3'd7;

	typedef logic [NUM_CH-1:0][ACT_W-1:0] act_vec_t;
	typedef logic [NUM_CH-1:0][ACC_W-1:0] acc_vec_t;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

	// One directed step: either a register write or a pixel. Pixels with
	// known_res set carry their result; the rest go through the model.
	typedef struct {
		row_kind_e                  kind;
		logic [CFG_IDX_BITS-1:0]    idx;
		logic [CFG_DATA_BITS-1:0]   data;
		act_vec_t                   act;
		acc_vec_t                   acc;
		bit                         known_res;
		acc_vec_t                   res;
	} dir_row_t;

	localparam int NUM_DIR = 25;

	// Order of fields: kind, index, data, activations {ch3..ch0},
	// accumulators {ch3..ch0}, result typed in, result.
	dir_row_t steps [NUM_DIR] = '{
		// weights are zero after reset: results equal the accumulators
		'{ROW_PIX, '0, '0, '0, '0, 1'b1, '0},
		'{ROW_PIX, '0, '0, {4{16'h7FFF}},
			{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
			{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF}},
		'{ROW_PIX, '0, '0, {4{16'h8000}},
			{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
			{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}},
		// +1.0, -1.0, largest and smallest weight, one value per row
		'{ROW_CFG, REG_WEIGHT_ROW0, 64'h4000_4000_4000_4000, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_WEIGHT_ROW1, 64'hC000_C000_C000_C000, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_WEIGHT_ROW2, 64'h7FFF_7FFF_7FFF_7FFF, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_WEIGHT_ROW3, 64'h8000_8000_8000_8000, '0, '0, 1'b0, '0},
		// activations of 1.0: each row sums its own four weights
		'{ROW_PIX, '0, '0, {4{16'h0100}}, '0, 1'b1,
			{32'hFFF8_0000, 32'h0007_FFF0, 32'hFFFC_0000, 32'h0004_0000}},
		// saturation both ways, smallest times smallest
		'{ROW_PIX, '0, '0, {4{16'h7FFF}}, {4{32'h7FFF_FFFF}}, 1'b0, '0},
		'{ROW_PIX, '0, '0, {4{16'h8000}}, {4{32'h8000_0000}}, 1'b0, '0},
		'{ROW_PIX, '0, '0, {4{16'h8000}}, {4{32'h7FFF_FFFF}}, 1'b0, '0},
		// inexact negative products round toward minus infinity
		'{ROW_PIX, '0, '0, {4{16'hFFFF}}, '0, 1'b0, '0},
		// one input, one output: only channel 0 moves, by 1.0
		'{ROW_CFG, REG_ACTIVE_IN_CHS, 64'd1, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_ACTIVE_OUT_CHS, 64'd1, '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, {4{16'h0100}}, {4{32'h1234_5678}}, 1'b1,
			{32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1235_5678}},
		// zero input channels: nothing contributes
		'{ROW_CFG, REG_ACTIVE_IN_CHS, 64'd0, '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, {4{16'h7FFF}},
			{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hDEAD_BEEF}, 1'b1,
			{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hDEAD_BEEF}},
		// zero output channels: everything passes through
		'{ROW_CFG, REG_ACTIVE_IN_CHS, 64'd4, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_ACTIVE_OUT_CHS, 64'd0, '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, {4{16'h8000}},
			{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000}},
		// counts above four act as four; upper data bits are dropped
		'{ROW_CFG, REG_ACTIVE_IN_CHS, 64'd7, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_ACTIVE_OUT_CHS, 64'hFFFF_FFFF_FFFF_FFFD, '0, '0, 1'b0, '0},
		// writes to unused indexes must not land anywhere
		'{ROW_CFG, REG_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_SPARE7, 64'h0000_0000_0000_0000, '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0100},
			{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000}, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [ACT_W-1:0] act_ch0 = '0, act_ch1 = '0, act_ch2 = '0, act_ch3 = '0;
	logic [ACC_W-1:0] acc_in0 = '0, acc_in1 = '0, acc_in2 = '0, acc_in3 = '0;

	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [ACC_W-1:0] acc_out0, acc_out1, acc_out2, acc_out3;

	pointwise_conv_4x4_mac_unit #(
		.ACT_BITS (ACT_W),
		.ACC_BITS (ACC_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.act_ch0   (act_ch0),
		.act_ch1   (act_ch1),
		.act_ch2   (act_ch2),
		.act_ch3   (act_ch3),
		.acc_in0   (acc_in0),
		.acc_in1   (acc_in1),
		.acc_in2   (acc_in2),
		.acc_in3   (acc_in3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.acc_out0  (acc_out0),
		.acc_out1  (acc_out1),
		.acc_out2  (acc_out2),
		.acc_out3  (acc_out3)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Local copy of the unit's registers, updated on each cfg transfer
	// ------------------------------------------------------------------
	logic [CFG_DATA_BITS-1:0] w_rows [NUM_CH] = '{default: '0};
	logic [CNT_BITS-1:0]      in_cnt  = ACTIVE_CHS_RESET;
	logic [CNT_BITS-1:0]      out_cnt = ACTIVE_CHS_RESET;

	acc_vec_t    acc_expect_q [$];   // updated accumulators still to come out
	int unsigned mismatches = 0;
	bit          send_idle  = 1'b0;  // sender inserts random gaps
	bit          recv_idle  = 1'b0;  // receiver inserts random stalls
	int unsigned stall_left = 0;
	int unsigned quiet      = 0;

	// acc_out = sat(acc_in + sum over active inputs of floor(act * w / 64)).
	// The exact sum fits easily in 64 bits; saturate once at the end, and
	// only on the active outputs.
	function automatic acc_vec_t mac_predict(input act_vec_t act, input acc_vec_t acc_in);
		acc_vec_t res;
		longint   sum;
		longint   prod;
		for (int j = 0; j < NUM_CH; j++) begin
			sum = longint'($signed(acc_in[j]));
			if (j < out_cnt) begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (i < in_cnt) begin
						prod = longint'($signed(act[i])) *
							longint'($signed(w_rows[j][i*WEIGHT_BITS +: WEIGHT_BITS]));
						sum += prod >>> PRODUCT_SHIFT;
					end
				end
				if (sum > ACC_MAX)
					sum = ACC_MAX;
				else if (sum < ACC_MIN)
					sum = ACC_MIN;
			end
			res[j] = sum[ACC_W-1:0];
		end
		return res;
	endfunction

	// Random field values, leaning on the extremes
	function automatic logic [ACT_W-1:0] pick_act();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return ACT_W'($urandom);
		endcase
	endfunction

	function automatic logic [ACC_W-1:0] pick_acc();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return {12'h7FF, 20'($urandom)};
			3: return {12'h800, 20'($urandom)};
			default: return ACC_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_row();
		logic [CFG_DATA_BITS-1:0] row;
		for (int i = 0; i < NUM_CH; i++) begin
			case ($urandom_range(0, 7))
				0: row[i*WEIGHT_BITS +: WEIGHT_BITS] = 16'h8000;
				1: row[i*WEIGHT_BITS +: WEIGHT_BITS] = 16'h7FFF;
				2: row[i*WEIGHT_BITS +: WEIGHT_BITS] = 16'h0000;
				default: row[i*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'($urandom);
			endcase
		end
		return row;
	endfunction

	// Mostly full blocks, some partial ones, now and then zero or above four
	function automatic logic [CFG_DATA_BITS-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return CFG_DATA_BITS'(0);
			1: return {32'($urandom), 29'($urandom), 3'($urandom_range(5, 7))};
			2, 3, 4: return CFG_DATA_BITS'(4);
			default: return CFG_DATA_BITS'($urandom_range(1, 4));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus tasks
	// ------------------------------------------------------------------

	// One pixel transfer. in_valid is left high so a back-to-back pixel
	// does not toggle it; close_burst drops it.
	task automatic send_pixel(input act_vec_t act, input acc_vec_t acc,
			input bit known_res, input acc_vec_t res);
		int unsigned gap;
		acc_vec_t    want;
		gap  = send_idle ? $urandom_range(0, MAX_GAP) : 0;
		want = known_res ? res : mac_predict(act, acc);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		act_ch0  <= act[0];
		act_ch1  <= act[1];
		act_ch2  <= act[2];
		act_ch3  <= act[3];
		acc_in0  <= acc[0];
		acc_in1  <= acc[1];
		acc_in2  <= acc[2];
		acc_in3  <= acc[3];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		acc_expect_q.push_back(want);
	endtask

	task automatic close_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every expected result has been seen; one result per pixel,
	// so an empty queue means an empty pipeline.
	task automatic wait_drained();
		while (acc_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WEIGHT_ROW0:    w_rows[0] = data;
			REG_WEIGHT_ROW1:    w_rows[1] = data;
			REG_WEIGHT_ROW2:    w_rows[2] = data;
			REG_WEIGHT_ROW3:    w_rows[3] = data;
			REG_ACTIVE_IN_CHS:  in_cnt = data[CNT_BITS-1:0];
			REG_ACTIVE_OUT_CHS: out_cnt = data[CNT_BITS-1:0];
			default: ;   // unused index, dropped
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls drawn after each transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drain_side
		int unsigned n;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				out_ready <= 1'b1;
		end else if (out_valid && out_ready) begin
			n = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (n != 0) begin
				out_ready  <= 1'b0;
				stall_left <= n;
			end
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result check: each output transfer against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		acc_vec_t got;
		acc_vec_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {acc_out3, acc_out2, acc_out1, acc_out0};
			if (acc_expect_q.size() == 0) begin
				$error("unexpected output transfer: acc_out0..3 = %h %h %h %h",
					got[0], got[1], got[2], got[3]);
				mismatches++;
			end else begin
				want = acc_expect_q.pop_front();
				for (int j = 0; j < NUM_CH; j++) begin
					if (got[j] !== want[j]) begin
						$error("acc_out%0d: expected %0d, got %0d", j,
							$signed(want[j]), $signed(got[j]));
						mismatches++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any transfer on any channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		act_vec_t act;
		acc_vec_t acc;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, with gaps and stalls on
		send_idle = 1'b1;
		recv_idle = 1'b1;
		foreach (steps[s]) begin
			if (steps[s].kind == ROW_CFG) begin
				close_burst();
				wait_drained();
				write_reg(steps[s].idx, steps[s].data);
			end else begin
				send_pixel(steps[s].act, steps[s].acc, steps[s].known_res, steps[s].res);
			end
		end

		// Random phases: new registers while empty, then a pixel stream
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			close_burst();
			wait_drained();
			write_reg(REG_WEIGHT_ROW0, pick_row());
			write_reg(REG_WEIGHT_ROW1, pick_row());
			write_reg(REG_WEIGHT_ROW2, pick_row());
			write_reg(REG_WEIGHT_ROW3, pick_row());
			// first phase full block, second single channel, then random
			if (ph == 0) begin
				write_reg(REG_ACTIVE_IN_CHS, CFG_DATA_BITS'(4));
				write_reg(REG_ACTIVE_OUT_CHS, CFG_DATA_BITS'(4));
			end else if (ph == 1) begin
				write_reg(REG_ACTIVE_IN_CHS, CFG_DATA_BITS'(1));
				write_reg(REG_ACTIVE_OUT_CHS, CFG_DATA_BITS'(1));
			end else begin
				write_reg(REG_ACTIVE_IN_CHS, pick_count());
				write_reg(REG_ACTIVE_OUT_CHS, pick_count());
			end
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7,
					{32'($urandom), 32'($urandom)});

			// phase 0 streams flat out; phase 1 back-pressures a full-rate
			// sender; the rest mix at random
			if (ph == 0) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end else if (ph == 1) begin
				send_idle = 1'b0;
				recv_idle = 1'b1;
			end else begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end

			for (int k = 0; k < PHASE_PIXELS; k++) begin
				for (int i = 0; i < NUM_CH; i++) begin
					act[i] = pick_act();
					acc[i] = pick_acc();
				end
				send_pixel(act, acc, 1'b0, '0);
				// sender holds off mid-stream until everything is out
				if (ph == PAUSE_PHASE && k == PHASE_PIXELS / 2) begin
					close_burst();
					wait_drained();
				end
			end
		end

		close_burst();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
